[hdl/tklb_pkg.sv]
package tklb_pkg;

    localparam int KEY_W   = 32;
    localparam int SCORE_W = 64;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 5;
    localparam int BOARD_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 1'b1;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_IGNORED    = 3'd0,
        ST_RAISED     = 3'd1,
        ST_KEPT       = 3'd2,
        ST_FREE       = 3'd3,
        ST_REPLACED   = 3'd4,
        ST_NOT_PLACED = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_WIPE,
        S_SCAN,
        S_SH_SETUP,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        [KEY_W-1:0]   key;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] tb;
    } t_entry;

endpackage

[hdl/top_k_leaderboard_update_unit.sv]
// Channel  | handshake                   | payload
// ---------+-----------------------------+-----------------------------------------------
// in       | i_in_valid / o_in_ready     | i_command, i_board, i_entry_key, i_score, i_tiebreak
// out      | o_out_valid / i_out_ready   | o_status, o_position
// cfg      | i_cfg_wr_en                 | i_cfg_idx, i_cfg_wdata
//
// One word at a time through a sequencer around a table memory with one read and one write port.
// Update: the sequencer scans slots up to the key or the first free slot (every slot when the
// board is full), then shifts the entries that the new entry climbs past and writes it; a word that
// leaves the board unchanged writes nothing. Ignored words skip the scan. Clear: one row per cycle.
// After reset the table is zeroed; o_in_ready stays low meanwhile.
// A waiting output word does not block the next accept; it only holds the next result.
module top_k_leaderboard_update_unit #(
    parameter int BOARDS = 8,
    parameter int SLOTS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [tklb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tklb_pkg::SCORE_W-1:0]        i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [tklb_pkg::BOARD_W-1:0]        i_board,
    input  logic signed [tklb_pkg::KEY_W-1:0]   i_entry_key,
    input  logic signed [tklb_pkg::SCORE_W-1:0] i_score,
    input  logic signed [tklb_pkg::SCORE_W-1:0] i_tiebreak,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tklb_pkg::STAT_W-1:0]         o_status,
    output logic [tklb_pkg::POS_W-1:0]          o_position
);
    import tklb_pkg::*;

    localparam int TOTAL = BOARDS * SLOTS;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(SLOTS);
    localparam int SCW   = $clog2(SLOTS + 1);
    localparam logic [POS_W-1:0] POS_NONE = POS_W'(SLOTS);

    // configuration
    logic                      r_enable;
    logic signed [SCORE_W-1:0] r_min_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_min_value <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:    r_enable    <= i_cfg_wdata[0];
                CFG_MIN_VALUE: r_min_value <= i_cfg_wdata;
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    // table memory
    t_entry          r_mem [TOTAL];
    t_entry          r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    t_entry          mem_wd;
    logic [AW-1:0]   mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // sequencer state
    t_state                    r_state, n_state;
    logic [AW-1:0]             r_cnt, n_cnt;
    logic                      r_cmd, n_cmd;
    logic [BOARD_W-1:0]        r_board, n_board;
    logic [KEY_W-1:0]          r_key, n_key;
    logic signed [SCORE_W-1:0] r_score, n_score;
    logic signed [SCORE_W-1:0] r_tb, n_tb;
    logic [AW-1:0]             r_base, n_base;
    logic [SCW-1:0]            r_idx, n_idx;
    logic [SW-1:0]             r_eidx, n_eidx;
    logic                      r_pend, n_pend;
    logic                      r_lt_found, n_lt_found;
    logic [SW-1:0]             r_lt_idx, n_lt_idx;
    logic signed [SCORE_W-1:0] r_min_score, n_min_score;
    logic signed [SCORE_W-1:0] r_min_tb, n_min_tb;
    logic [SW-1:0]             r_min_slot, n_min_slot;
    logic [SW-1:0]             r_target, n_target;
    logic [SW-1:0]             r_ridx, n_ridx;
    logic [SW-1:0]             r_pidx, n_pidx;
    logic                      r_more, n_more;
    t_status                   r_res_status, n_res_status;
    logic [POS_W-1:0]          r_res_pos, n_res_pos;
    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status, n_out_status;
    logic [POS_W-1:0]          r_out_pos, n_out_pos;

    logic                      board_ok;
    logic                      upd_ok;
    logic                      lt_now;
    logic [SW-1:0]             jj;
    logic                      min_above;
    logic signed [SCORE_W-1:0] cur_min_score;
    logic [SW-1:0]             cur_min_slot;
    logic                      cur_lt_found;
    logic [SW-1:0]             cur_lt_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_position  = r_out_pos;

    assign board_ok = 32'(r_board) < BOARDS;
    assign upd_ok   = r_enable && (r_key != '0) && (r_score > 64'sd0)
                      && (r_score >= r_min_value);

    // slot compare unit, shared by every scan step
    assign lt_now    = r_rd_data.score < r_score;
    assign jj        = r_lt_found ? r_lt_idx : r_eidx;
    assign min_above = (r_min_score != r_rd_data.score) ? (r_min_score > r_rd_data.score)
                                                        : (r_min_tb > r_rd_data.tb);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_board      = r_board;
        n_key        = r_key;
        n_score      = r_score;
        n_tb         = r_tb;
        n_base       = r_base;
        n_idx        = r_idx;
        n_eidx       = r_eidx;
        n_pend       = r_pend;
        n_lt_found   = r_lt_found;
        n_lt_idx     = r_lt_idx;
        n_min_score  = r_min_score;
        n_min_tb     = r_min_tb;
        n_min_slot   = r_min_slot;
        n_target     = r_target;
        n_ridx       = r_ridx;
        n_pidx       = r_pidx;
        n_more       = r_more;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_ra       = '0;
        cur_min_score = r_min_score;
        cur_min_slot  = r_min_slot;
        cur_lt_found  = r_lt_found;
        cur_lt_idx    = r_lt_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                if (r_cnt == AW'(TOTAL - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_command;
                    n_board = i_board;
                    n_key   = i_entry_key;
                    n_score = i_score;
                    n_tb    = i_tiebreak;
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_base     = AW'(r_board) * AW'(SLOTS);
                n_cnt      = '0;
                n_idx      = '0;
                n_pend     = 1'b0;
                n_lt_found = 1'b0;
                n_res_pos  = POS_NONE;
                if (!board_ok) begin
                    n_res_status = ST_IGNORED;
                    n_state      = S_DONE;
                end else if (r_cmd == CMD_CLEAR) begin
                    n_state = S_WIPE;
                end else if (!upd_ok) begin
                    n_res_status = ST_IGNORED;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_WIPE: begin
                mem_we = 1'b1;
                mem_wa = r_base + r_cnt;
                if (r_cnt == AW'(SLOTS - 1)) begin
                    n_res_status = ST_NOT_PLACED;
                    n_state      = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_SCAN: begin
                // issue the next slot read while the previous one is evaluated
                if (r_idx != SCW'(SLOTS)) begin
                    mem_ra = r_base + AW'(r_idx[SW-1:0]);
                    n_idx  = r_idx + 1'b1;
                    n_eidx = r_idx[SW-1:0];
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_rd_data.key == r_key) begin
                        n_target = r_eidx;
                        if (lt_now) begin
                            n_res_status = ST_RAISED;
                            n_lt_idx     = jj;
                            n_state      = S_SH_SETUP;
                        end else begin
                            n_res_status = ST_KEPT;
                            n_res_pos    = POS_W'(r_eidx);
                            n_state      = S_DONE;
                        end
                    end else if (r_rd_data.key == '0) begin
                        n_target     = r_eidx;
                        n_res_status = ST_FREE;
                        n_lt_idx     = jj;
                        n_state      = S_SH_SETUP;
                    end else begin
                        if (!r_lt_found && lt_now) begin
                            cur_lt_found = 1'b1;
                            cur_lt_idx   = r_eidx;
                        end
                        if ((r_eidx == '0) || min_above) begin
                            cur_min_score = r_rd_data.score;
                            cur_min_slot  = r_eidx;
                            n_min_tb      = r_rd_data.tb;
                        end
                        n_lt_found  = cur_lt_found;
                        n_lt_idx    = cur_lt_idx;
                        n_min_score = cur_min_score;
                        n_min_slot  = cur_min_slot;
                        if (r_eidx == SW'(SLOTS - 1)) begin
                            // board full: replace the lowest entry or drop the word
                            if (r_score > cur_min_score) begin
                                n_target     = cur_min_slot;
                                n_res_status = ST_REPLACED;
                                n_state      = S_SH_SETUP;
                            end else begin
                                n_res_status = ST_NOT_PLACED;
                                n_state      = S_DONE;
                            end
                        end
                    end
                end
            end

            S_SH_SETUP: begin
                n_pend = 1'b0;
                n_more = 1'b1;
                n_ridx = r_target - 1'b1;
                if (r_target == r_lt_idx) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_SHIFT;
                end
            end

            S_SHIFT: begin
                // move entries lt_idx..target-1 down by one slot, highest first
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_base + AW'(r_pidx + 1'b1);
                    mem_wd = r_rd_data;
                end
                if (r_more) begin
                    mem_ra = r_base + AW'(r_ridx);
                    n_pidx = r_ridx;
                    n_pend = 1'b1;
                    if (r_ridx == r_lt_idx) begin
                        n_more = 1'b0;
                    end else begin
                        n_ridx = r_ridx - 1'b1;
                    end
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                mem_we       = 1'b1;
                mem_wa       = r_base + AW'(r_lt_idx);
                mem_wd.key   = r_key;
                mem_wd.score = r_score;
                mem_wd.tb    = r_tb;
                n_res_pos    = POS_W'(r_lt_idx);
                n_state      = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = r_res_pos;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_more      <= 1'b0;
            r_lt_found  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_more      <= n_more;
            r_lt_found  <= n_lt_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_board      <= n_board;
        r_key        <= n_key;
        r_score      <= n_score;
        r_tb         <= n_tb;
        r_base       <= n_base;
        r_idx        <= n_idx;
        r_eidx       <= n_eidx;
        r_lt_idx     <= n_lt_idx;
        r_min_score  <= n_min_score;
        r_min_tb     <= n_min_tb;
        r_min_slot   <= n_min_slot;
        r_target     <= n_target;
        r_ridx       <= n_ridx;
        r_pidx       <= n_pidx;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    // one word in flight: an accepted word drops ready on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an accepted word");

    // the new entry never lands below the slot it came from
    a_dest_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_SETUP) |-> (r_lt_idx <= r_target))
        else $error("insert slot below target slot");

    // words that leave nothing on the board report no position
    a_none_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_status == ST_IGNORED || r_out_status == ST_NOT_PLACED))
        |-> (o_position == POS_NONE))
        else $error("position reported for an unplaced word");

endmodule
